// File: sv/mltwa_pkg.sv
// Package for the MAC learning table: depths, opcodes, status codes, states, hash.
// No dependencies.
package mltwa_pkg;
    localparam int TABLE_DEPTH    = 1024;
    localparam int BRIDGE_DOMAINS = 16;
    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int BD_W   = (BRIDGE_DOMAINS > 1) ? $clog2(BRIDGE_DOMAINS) : 1;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_LOOKUP = 3'd2;
    localparam logic [2:0] OP_FLUSH  = 3'd3;
    localparam logic [2:0] OP_AGE    = 3'd4;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_BRIDGE = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
    localparam logic [1:0] ST_NO_SPACE   = 2'd3;

    localparam logic CFG_MAX_ENTRIES = 1'b0;
    localparam logic CFG_AGING       = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_SWEEP_RD, S_SWEEP_EX, S_DONE
    } state_t;

    typedef struct packed {
        logic        used;
        logic [47:0] key_mac;
        logic [15:0] key_bd;
        logic [15:0] port;
        logic        is_static;
        logic [31:0] seen_sec;
    } entry_t;

    // One multiply-by-31 step: h*31 + b as (h<<5) - h + b.
    function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
        hash_step = (h << 5) - h + {24'd0, b};
    endfunction
endpackage

// File: sv/mac_learning_table_with_aging.sv
// Top level of the MAC learning table with aging.
// Depends on mltwa_pkg.
//
//  channel | signals                                             | dir
//  request | in_valid/in_ready, opcode..now_seconds              | in
//  result  | out_valid/out_ready, status,found_port,removed_count | out
//  config  | cfg_valid/cfg_ready, cfg_index, cfg_data            | in
//
// Add, delete, lookup: hash six bytes and issue the slot read, then compare and write
// back, then load the result and raise out_valid; the next request goes in only once
// that result is taken. Flush and age walk every slot, reading and then deciding each
// one; a flush of a bad bridge or an age tick with aging off skips the walk. Reset
// zeroes the bridge counters, then a clearing pass marks every slot unused with
// in_ready low.
// A waiting result blocks only the next request; the table holds all its state.
module mac_learning_table_with_aging (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [15:0] bridge_domain,
    input  logic [47:0] mac_address,
    input  logic [15:0] port_id,
    input  logic        is_static,
    input  logic        flush_dynamic,
    input  logic [31:0] now_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] found_port,
    output logic [10:0] removed_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int SW = mltwa_pkg::SLOT_W;
    localparam int BW = mltwa_pkg::BD_W;

    mltwa_pkg::state_t state_reg, state_next;
    logic [2:0]  op_reg;
    logic [15:0] bd_reg;
    logic [47:0] mac_reg;
    logic [15:0] port_reg;
    logic        stat_reg, dyn_reg;
    logic [31:0] now_reg;
    logic [31:0] hash_reg;
    logic [2:0]  hcnt_reg;
    logic [SW:0] idx_reg;
    logic [10:0] removed_reg;
    logic [10:0] max_reg;
    logic [31:0] aging_reg;
    logic [10:0] count_reg [mltwa_pkg::BRIDGE_DOMAINS];
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [15:0] found_reg;

    // Table memory: one write port and one read port, registered read; the used flag lives in each entry.
    mltwa_pkg::entry_t mem [mltwa_pkg::TABLE_DEPTH];
    mltwa_pkg::entry_t rd_q;
    logic          wr_en;
    logic [SW-1:0] wr_addr, rd_addr;
    mltwa_pkg::entry_t wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_q <= mem[rd_addr];
    end

    logic [SW-1:0] slot;
    logic [SW-1:0] cur;
    logic          bd_ok;
    logic [BW-1:0] bdi;
    logic [BW-1:0] ent_bdi;
    logic          ent_bd_ok;
    logic          hit;
    logic          drop;
    logic          inc_cnt;
    logic          dec_cnt;
    logic [7:0]    hbyte;

    assign slot    = hash_reg[SW-1:0];
    assign cur     = (state_reg == mltwa_pkg::S_SWEEP_EX) ? idx_reg[SW-1:0] : slot;
    assign bd_ok   = bd_reg < 16'(mltwa_pkg::BRIDGE_DOMAINS);
    assign bdi     = bd_reg[BW-1:0];
    assign ent_bdi = rd_q.key_bd[BW-1:0];
    assign ent_bd_ok = rd_q.key_bd < 16'(mltwa_pkg::BRIDGE_DOMAINS);
    assign hit     = rd_q.used && rd_q.key_bd == bd_reg && rd_q.key_mac == mac_reg;
    assign hbyte   = mac_reg[47 - 8*hcnt_reg -: 8];

    assign in_ready  = (state_reg == mltwa_pkg::S_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign found_port = found_reg;
    assign removed_count = removed_reg;

    // Next state, memory access and the per-request decision.
    always_comb
    begin
        state_next = state_reg;
        rd_addr = slot;
        wr_en   = 1'b0;
        wr_addr = cur;
        wr_data = rd_q;
        drop    = 1'b0;
        inc_cnt = 1'b0;
        dec_cnt = 1'b0;
        case (state_reg)
            mltwa_pkg::S_CLEAR:
            begin
                // mark one slot unused per cycle after reset
                wr_en   = 1'b1;
                wr_addr = idx_reg[SW-1:0];
                wr_data = '0;
                if (idx_reg == (SW+1)'(mltwa_pkg::TABLE_DEPTH - 1))
                    state_next = mltwa_pkg::S_IDLE;
            end
            mltwa_pkg::S_IDLE:
                if (in_valid && in_ready)
                    state_next = mltwa_pkg::S_READ;
            mltwa_pkg::S_READ:
            begin
                // hash one byte per cycle, then issue the slot read
                if (hcnt_reg == 3'd6)
                begin
                    if (op_reg == mltwa_pkg::OP_FLUSH || op_reg == mltwa_pkg::OP_AGE)
                    begin
                        if ((op_reg == mltwa_pkg::OP_FLUSH && !bd_ok) ||
                            (op_reg == mltwa_pkg::OP_AGE && aging_reg == 32'd0))
                            state_next = mltwa_pkg::S_DONE;
                        else
                            state_next = mltwa_pkg::S_SWEEP_RD;
                    end
                    else
                        state_next = mltwa_pkg::S_EXEC;
                end
            end
            mltwa_pkg::S_EXEC:
            begin
                state_next = mltwa_pkg::S_DONE;
                if (bd_ok)
                begin
                    case (op_reg)
                        mltwa_pkg::OP_ADD:
                            if (!(!stat_reg && max_reg != 11'd0 && count_reg[bdi] >= max_reg)
                                && (hit || !rd_q.used))
                            begin
                                wr_en = 1'b1;
                                wr_data.used = 1'b1;
                                wr_data.key_bd = bd_reg;
                                wr_data.key_mac = mac_reg;
                                wr_data.port = port_reg;
                                wr_data.is_static = stat_reg;
                                wr_data.seen_sec = now_reg;
                                inc_cnt = !hit;
                            end
                        mltwa_pkg::OP_DELETE:
                            if (hit)
                            begin
                                drop = 1'b1;
                                dec_cnt = 1'b1;
                                wr_en = 1'b1;
                                wr_data.used = 1'b0;
                            end
                        mltwa_pkg::OP_LOOKUP:
                            if (hit && !rd_q.is_static)
                            begin
                                wr_en = 1'b1;
                                wr_data.seen_sec = now_reg;
                            end
                        default: ;
                    endcase
                end
            end
            mltwa_pkg::S_SWEEP_RD:
            begin
                rd_addr = idx_reg[SW-1:0];
                state_next = mltwa_pkg::S_SWEEP_EX;
            end
            mltwa_pkg::S_SWEEP_EX:
            begin
                if (rd_q.used)
                begin
                    if (op_reg == mltwa_pkg::OP_FLUSH)
                        drop = rd_q.key_bd == bd_reg &&
                               (port_reg == 16'd0 || rd_q.port == port_reg) &&
                               !(dyn_reg && rd_q.is_static);
                    else
                        drop = !rd_q.is_static && (now_reg - rd_q.seen_sec) > aging_reg;
                end
                dec_cnt = drop;
                if (drop)
                begin
                    wr_en = 1'b1;
                    wr_data.used = 1'b0;
                end
                if (idx_reg == (SW+1)'(mltwa_pkg::TABLE_DEPTH - 1))
                    state_next = mltwa_pkg::S_DONE;
                else
                    state_next = mltwa_pkg::S_SWEEP_RD;
            end
            mltwa_pkg::S_DONE:
                state_next = mltwa_pkg::S_IDLE;
            default:
                state_next = mltwa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mltwa_pkg::S_CLEAR;
            for (int b = 0; b < mltwa_pkg::BRIDGE_DOMAINS; b++)
                count_reg[b] <= 11'd0;
            out_valid_reg <= 1'b0;
            max_reg       <= 11'd1024;
            aging_reg     <= 32'd300;
            hcnt_reg      <= 3'd0;
            idx_reg       <= '0;
            removed_reg   <= 11'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                if (cfg_index == mltwa_pkg::CFG_MAX_ENTRIES)
                    max_reg <= cfg_data[10:0];
                else
                    aging_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                mltwa_pkg::S_CLEAR:
                    idx_reg <= idx_reg + 1'b1;
                mltwa_pkg::S_IDLE:
                begin
                    hcnt_reg <= 3'd0;
                    idx_reg  <= '0;
                    // hold the count of a waiting result until a new request goes in
                    if (in_valid && in_ready)
                        removed_reg <= 11'd0;
                end
                mltwa_pkg::S_READ:
                    if (hcnt_reg != 3'd6)
                        hcnt_reg <= hcnt_reg + 3'd1;
                mltwa_pkg::S_SWEEP_EX:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (drop && removed_reg != 11'h7FF)
                        removed_reg <= removed_reg + 11'd1;
                end
                mltwa_pkg::S_DONE:
                    out_valid_reg <= 1'b1;
                default: ;
            endcase
            if (inc_cnt)
                count_reg[bdi] <= count_reg[bdi] + 11'd1;
            if (dec_cnt && ent_bd_ok && count_reg[ent_bdi] != 11'd0)
                count_reg[ent_bdi] <= count_reg[ent_bdi] - 11'd1;
        end
    end

    // Request capture, hash and result payload.
    always_ff @(posedge clk)
    begin
        if (state_reg == mltwa_pkg::S_IDLE && in_valid && in_ready)
        begin
            op_reg   <= opcode;
            bd_reg   <= bridge_domain;
            mac_reg  <= mac_address;
            port_reg <= port_id;
            stat_reg <= is_static;
            dyn_reg  <= flush_dynamic;
            now_reg  <= now_seconds;
            hash_reg <= {16'd0, bridge_domain};
        end
        else if (state_reg == mltwa_pkg::S_READ && hcnt_reg != 3'd6)
            hash_reg <= mltwa_pkg::hash_step(hash_reg, hbyte);
        if (state_reg == mltwa_pkg::S_READ)
        begin
            found_reg <= 16'd0;
            if (op_reg <= mltwa_pkg::OP_FLUSH && !bd_ok)
                status_reg <= mltwa_pkg::ST_BAD_BRIDGE;
            else
                status_reg <= mltwa_pkg::ST_OK;
        end
        if (state_reg == mltwa_pkg::S_EXEC && bd_ok)
        begin
            case (op_reg)
                mltwa_pkg::OP_ADD:
                    if ((!stat_reg && max_reg != 11'd0 && count_reg[bdi] >= max_reg) ||
                        (!hit && rd_q.used))
                        status_reg <= mltwa_pkg::ST_NO_SPACE;
                mltwa_pkg::OP_DELETE:
                    if (!hit)
                        status_reg <= mltwa_pkg::ST_NOT_FOUND;
                mltwa_pkg::OP_LOOKUP:
                    if (hit)
                        found_reg <= rd_q.port;
                    else
                        status_reg <= mltwa_pkg::ST_NOT_FOUND;
                default: ;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != mltwa_pkg::S_IDLE) |-> !in_ready)
        else $error("request taken while busy");
    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mltwa_pkg::S_DONE) |=> out_valid)
        else $error("result missing after done");
    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(inc_cnt && drop))
        else $error("insert and drop in one cycle");
endmodule

// File: bench/mltwa_checker.sv
// Checker for the MAC learning table: watches the request, result and config channels,
// keeps its own copy of the table and compares every result. Depends on mltwa_pkg.
`timescale 1ns / 100ps
module mltwa_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [15:0] bridge_domain,
    input  logic [47:0] mac_address,
    input  logic [15:0] port_id,
    input  logic        is_static,
    input  logic        flush_dynamic,
    input  logic [31:0] now_seconds,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [15:0] found_port,
    input  logic [10:0] removed_count,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    typedef struct {
        logic [1:0]  status;
        logic [15:0] port;
        logic [10:0] removed;
    } table_result_t;

    table_result_t results_due[$];

    bit          slot_used [mltwa_pkg::TABLE_DEPTH];
    bit [63:0]   slot_key  [mltwa_pkg::TABLE_DEPTH];
    bit [15:0]   slot_port [mltwa_pkg::TABLE_DEPTH];
    bit          slot_fixed[mltwa_pkg::TABLE_DEPTH];
    bit [31:0]   slot_seen [mltwa_pkg::TABLE_DEPTH];
    int          bd_fill   [mltwa_pkg::BRIDGE_DOMAINS];
    bit [10:0]   fill_limit;
    bit [31:0]   age_limit;

    function automatic int slot_index(bit [15:0] bd, bit [47:0] mac);
        bit [31:0] h;
        h = {16'd0, bd};
        for (int i = 5; i >= 0; i--)
            h = h * 32'd31 + {24'd0, mac[8*i +: 8]};
        return int'(h % mltwa_pkg::TABLE_DEPTH);
    endfunction

    function automatic void evict(int s);
        int bd;
        bd = int'(slot_key[s][63:48]);
        slot_used[s] = 1'b0;
        if (bd < mltwa_pkg::BRIDGE_DOMAINS && bd_fill[bd] > 0)
            bd_fill[bd]--;
    endfunction

    function automatic table_result_t predict_request(bit [2:0] op, bit [15:0] bd,
            bit [47:0] mac, bit [15:0] port, bit fixed, bit dyn_only, bit [31:0] now);
        table_result_t r;
        bit [63:0] key;
        int s;
        int gone;
        bit hit;
        r = '{mltwa_pkg::ST_OK, 16'd0, 11'd0};
        key = {bd, mac};
        s = slot_index(bd, mac);
        hit = slot_used[s] && slot_key[s] == key;
        gone = 0;
        if (op <= mltwa_pkg::OP_FLUSH && bd >= mltwa_pkg::BRIDGE_DOMAINS) begin
            r.status = mltwa_pkg::ST_BAD_BRIDGE;
        end
        else if (op == mltwa_pkg::OP_ADD) begin
            if (!fixed && fill_limit != 0 && bd_fill[bd] >= fill_limit) begin
                r.status = mltwa_pkg::ST_NO_SPACE;
            end
            else if (hit) begin
                slot_port[s] = port;
                slot_fixed[s] = fixed;
                slot_seen[s] = now;
            end
            else if (slot_used[s]) begin
                r.status = mltwa_pkg::ST_NO_SPACE;
            end
            else begin
                slot_used[s] = 1'b1;
                slot_key[s] = key;
                slot_port[s] = port;
                slot_fixed[s] = fixed;
                slot_seen[s] = now;
                bd_fill[bd]++;
            end
        end
        else if (op == mltwa_pkg::OP_DELETE) begin
            if (hit) evict(s);
            else r.status = mltwa_pkg::ST_NOT_FOUND;
        end
        else if (op == mltwa_pkg::OP_LOOKUP) begin
            if (hit) begin
                r.port = slot_port[s];
                if (!slot_fixed[s]) slot_seen[s] = now;
            end
            else r.status = mltwa_pkg::ST_NOT_FOUND;
        end
        else if (op == mltwa_pkg::OP_FLUSH) begin
            for (int i = 0; i < mltwa_pkg::TABLE_DEPTH; i++) begin
                if (slot_used[i] && slot_key[i][63:48] == bd
                        && (port == 0 || slot_port[i] == port)
                        && !(dyn_only && slot_fixed[i])) begin
                    evict(i);
                    gone++;
                end
            end
        end
        else if (op == mltwa_pkg::OP_AGE && age_limit != 0) begin
            for (int i = 0; i < mltwa_pkg::TABLE_DEPTH; i++) begin
                if (slot_used[i] && !slot_fixed[i]
                        && (now - slot_seen[i]) > age_limit) begin
                    evict(i);
                    gone++;
                end
            end
        end
        r.removed = (gone > 2047) ? 11'd2047 : gone[10:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("checker: %s got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < mltwa_pkg::TABLE_DEPTH; i++) slot_used[i] = 1'b0;
            for (int i = 0; i < mltwa_pkg::BRIDGE_DOMAINS; i++) bd_fill[i] = 0;
            fill_limit = 11'd1024;
            age_limit = 32'd300;
            results_due.delete();
            pending <= 0;
        end
        else
        begin
            // Results first: one never returns in the cycle its request goes in.
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                    report_mismatch("unexpected result, status", status, -1);
                else
                begin
                    want = results_due.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (found_port !== want.port)
                        report_mismatch("found_port", found_port, want.port);
                    if (removed_count !== want.removed)
                        report_mismatch("removed_count", removed_count, want.removed);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == mltwa_pkg::CFG_MAX_ENTRIES) fill_limit = cfg_data[10:0];
                else age_limit = cfg_data;
            end
            if (in_valid && in_ready)
                results_due.push_back(predict_request(opcode, bridge_domain, mac_address,
                    port_id, is_static, flush_dynamic, now_seconds));
            pending <= results_due.size();
        end
    end
endmodule

// File: bench/mac_learning_table_with_aging_test.sv
// Top of the MAC learning table bench: clock, reset, request/config stimulus and verdict.
// Depends on mltwa_pkg, mltwa_checker and the block itself.
`timescale 1ns / 100ps
module mac_learning_table_with_aging_test;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int KEY_POOL = 20;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  opcode;
    logic [15:0] bridge_domain;
    logic [47:0] mac_address;
    logic [15:0] port_id;
    logic        is_static;
    logic        flush_dynamic;
    logic [31:0] now_seconds;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [15:0] found_port;
    logic [10:0] removed_count;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    int fail_count;
    int pending;
    int cycle_count;
    bit steady;            // when set, both sides run with no idle cycles
    bit [31:0] clock_sec;  // running wall clock fed to requests
    bit [15:0] pool_bd [KEY_POOL];
    bit [47:0] pool_mac[KEY_POOL];

    mac_learning_table_with_aging u_top (.*);

    mltwa_checker u_check (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Global watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("mac_learning_table_with_aging: mismatch");
            $finish;
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 18);
    endfunction

    // Result side: stall a random number of cycles before taking each result.
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = draw_gap();
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Drive one request; valid stays high across back-to-back requests.
    task automatic send_request(bit [2:0] op, bit [15:0] bd, bit [47:0] mac,
            bit [15:0] port, bit fixed, bit dyn_only, bit [31:0] now);
        int n;
        n = draw_gap();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        bridge_domain <= bd;
        mac_address   <= mac;
        port_id       <= port;
        is_static     <= fixed;
        flush_dynamic <= dyn_only;
        now_seconds   <= now;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drain every outstanding request, then write one register.
    task automatic write_register(bit idx, bit [31:0] value);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Hold a few bridges and colliding addresses so hits, limits and collisions recur.
    task automatic refill_key_pool();
        for (int i = 0; i < KEY_POOL; i++)
        begin
            pool_bd[i] = 16'($urandom_range(0, 3));
            if (i % 5 == 4)
            begin
                // Same slot as the previous key when the add gives low byte -31, next byte +1 with no further carry.
                pool_bd[i]  = pool_bd[i-1];
                pool_mac[i] = pool_mac[i-1] + 48'h100 - 48'd31;
            end
            else
                pool_mac[i] = 48'({$urandom(), $urandom()});
        end
    endtask

    task automatic random_request();
        int k;
        int pick;
        bit [2:0]  op;
        bit [15:0] bd;
        bit [47:0] mac;
        bit [15:0] port;
        k = $urandom_range(0, KEY_POOL - 1);
        bd = pool_bd[k];
        mac = pool_mac[k];
        if ($urandom_range(0, 99) < 12)
        begin
            bd = 16'($urandom_range(0, mltwa_pkg::BRIDGE_DOMAINS - 1));
            mac = 48'({$urandom(), $urandom()});
        end
        if ($urandom_range(0, 99) < 5) bd = 16'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 38) op = mltwa_pkg::OP_ADD;
        else if (pick < 63) op = mltwa_pkg::OP_LOOKUP;
        else if (pick < 82) op = mltwa_pkg::OP_DELETE;
        else if (pick < 88) op = mltwa_pkg::OP_AGE;
        else if (pick < 93) op = mltwa_pkg::OP_FLUSH;
        else op = 3'($urandom_range(5, 7));
        port = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 4)) : 16'($urandom());
        // Advance the clock slowly, with an occasional jump anywhere.
        if ($urandom_range(0, 99) < 3) clock_sec = $urandom();
        else clock_sec += $urandom_range(0, 4);
        send_request(op, bd, mac, port, $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
            clock_sec);
    endtask

    initial
    begin
        bit [31:0] limits [7] = '{1024, 0, 2047, 3, 1, 8, 1};
        bit [31:0] ages   [7] = '{300, 20, 32'hFFFF_FFFF, 10, 0, 50, 1};
        bit [47:0] mac_a = 48'h0A1B_2C3D_0040;
        bit [47:0] mac_b = 48'h0A1B_2C3D_0121;   // collides with mac_a in bridge 0
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = mltwa_pkg::OP_ADD;
        bridge_domain = 16'd0;
        mac_address = 48'd0;
        port_id = 16'd0;
        is_static = 1'b0;
        flush_dynamic = 1'b0;
        now_seconds = 32'd0;
        cfg_valid = 1'b0;
        cfg_index = mltwa_pkg::CFG_MAX_ENTRIES;
        cfg_data = 32'd0;
        cycle_count = 0;
        steady = 1'b0;
        clock_sec = 32'hFFFF_FF00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, collisions, bad bridges, unused opcodes, flush and age.
        send_request(mltwa_pkg::OP_ADD, 0, mac_a, 16'hFFFF, 0, 0, 32'd100);
        send_request(mltwa_pkg::OP_ADD, 0, mac_a, 16'h0002, 1, 0, 32'd101);
        send_request(mltwa_pkg::OP_LOOKUP, 0, mac_a, 0, 0, 0, 32'd102);
        send_request(mltwa_pkg::OP_ADD, 0, mac_b, 16'h0003, 0, 0, 32'd103);
        send_request(mltwa_pkg::OP_LOOKUP, 0, mac_b, 0, 0, 0, 32'd104);
        send_request(mltwa_pkg::OP_DELETE, 0, mac_b, 0, 0, 0, 32'd105);
        send_request(mltwa_pkg::OP_ADD, 16'(mltwa_pkg::BRIDGE_DOMAINS - 1),
            48'hFFFF_FFFF_FFFF, 16'd1, 0, 1, 32'hFFFF_FFFF);
        send_request(mltwa_pkg::OP_ADD, 16'(mltwa_pkg::BRIDGE_DOMAINS), mac_a, 16'd1, 0, 0,
            32'd0);
        send_request(mltwa_pkg::OP_LOOKUP, 16'hFFFF, mac_a, 0, 0, 0, 32'd0);
        send_request(mltwa_pkg::OP_DELETE, 16'(mltwa_pkg::BRIDGE_DOMAINS), mac_a, 0, 0, 0,
            32'd0);
        send_request(mltwa_pkg::OP_FLUSH, 16'hFFFF, 0, 0, 0, 1, 32'd0);
        send_request(3'd5, 0, mac_a, 16'hFFFF, 1, 1, 32'hFFFF_FFFF);
        send_request(3'd6, 0, mac_a, 0, 0, 0, 32'd0);
        send_request(3'd7, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 32'd0);
        send_request(mltwa_pkg::OP_LOOKUP, 0, 48'd0, 0, 0, 0, 32'd0);
        send_request(mltwa_pkg::OP_AGE, 16'hFFFF, 0, 0, 0, 0, 32'd500);
        send_request(mltwa_pkg::OP_FLUSH, 0, 0, 0, 0, 1, 32'd0);
        send_request(mltwa_pkg::OP_FLUSH, 16'(mltwa_pkg::BRIDGE_DOMAINS - 1), 0, 16'd1, 0, 0,
            32'd0);
        send_request(mltwa_pkg::OP_DELETE, 0, mac_a, 0, 0, 0, 32'd0);

        // Limit of one entry: the second dynamic add and a refresh of a present key fail.
        write_register(mltwa_pkg::CFG_MAX_ENTRIES, 32'd1);
        write_register(mltwa_pkg::CFG_AGING, 32'd5);
        send_request(mltwa_pkg::OP_ADD, 3, mac_a, 16'd7, 0, 0, 32'hFFFF_FFF0);
        send_request(mltwa_pkg::OP_ADD, 3, mac_b, 16'd7, 0, 0, 32'd0);
        send_request(mltwa_pkg::OP_ADD, 3, mac_a, 16'd8, 0, 0, 32'd0);
        send_request(mltwa_pkg::OP_ADD, 3, 48'h1234_5678_9ABC, 16'd9, 1, 0, 32'd0);
        send_request(mltwa_pkg::OP_AGE, 0, 0, 0, 0, 0, 32'd3);
        write_register(mltwa_pkg::CFG_AGING, 32'd0);
        send_request(mltwa_pkg::OP_AGE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 7; ph++)
        begin
            write_register(mltwa_pkg::CFG_MAX_ENTRIES, limits[ph]);
            write_register(mltwa_pkg::CFG_AGING, ages[ph]);
            refill_key_pool();
            for (int n = 0; n < 275; n++)
            begin
                if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
                random_request();
            end
            steady = 1'b0;
        end

        // Drain and let the block settle.
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("mac_learning_table_with_aging: match");
        else
            $display("mac_learning_table_with_aging: mismatch");
        $finish;
    end
endmodule
